@@ design/salc_pkg.sv @@
// Shared constants of the set-associative LRU cache lookup block.
package salc_pkg;

    // Field widths fixed by the interface
    localparam int ADDR_W     = 48;
    localparam int OUT_WAY_W  = 3;

    // Default geometry
    localparam int DEF_SETS        = 512;
    localparam int DEF_WAYS        = 8;
    localparam int DEF_BLOCK_BYTES = 64;

    // Sequencer state codes
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

endpackage

@@ design/set_assoc_lru_cache_lookup_top.sv @@
// Set-associative cache lookup with LRU replacement by saturating ages, one way per cycle.
//
// Each request carries one byte address; the block answers with hit and the way
// that hit or was filled. SETS and BLOCK_BYTES must be powers of two: the offset
// and set index are taken as bit fields of the address. Line state (valid, age)
// and tags sit in single-port-per-side memories of SETS*WAYS entries, and the
// sequencer walks the ways of one set through that one memory port: it reads
// and compares each way, writes back the ages of each way, then hands the
// result to the output register and returns to idle for the next accept. The
// hand-off waits while a held result is not yet taken. The result register
// lets the next request enter while a result still waits. After reset a
// clearing pass over all SETS*WAYS entries zeroes valid bits and ages; no
// request is taken until it is done.
module set_assoc_lru_cache_lookup_top
    import salc_pkg::*;
#(
    parameter int SETS        = DEF_SETS,
    parameter int WAYS        = DEF_WAYS,
    parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [ADDR_W-1:0]    i_byte_address,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_hit,
    output logic [OUT_WAY_W-1:0] o_way_used
);

    localparam int OFF_W     = $clog2(BLOCK_BYTES);
    localparam int SIDX_W    = $clog2(SETS);
    localparam int SET_W     = (SIDX_W > 0) ? SIDX_W : 1;
    localparam int TAG_W     = ADDR_W - OFF_W - SIDX_W;
    localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int AGE_W     = WAY_W;
    localparam int CNT_W     = $clog2(WAYS + 1);
    localparam int ENT_COUNT = SETS * WAYS;
    localparam int ENT_W     = (ENT_COUNT > 1) ? $clog2(ENT_COUNT) : 1;
    localparam int ST_W      = 1 + AGE_W;

    localparam logic [AGE_W-1:0] AGE_MAX  = AGE_W'(WAYS - 1);
    localparam logic [CNT_W-1:0] CNT_WAYS = CNT_W'(WAYS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WAYS - 1);
    localparam logic [ENT_W-1:0] ENT_LAST = ENT_W'(ENT_COUNT - 1);

    // Line memories: state is {valid, age}
    logic [ST_W-1:0]  mem_state [ENT_COUNT];
    logic [TAG_W-1:0] mem_tag   [ENT_COUNT];

    logic [2:0]       r_state;
    logic [CNT_W-1:0] r_cnt;
    logic [ENT_W-1:0] r_clr;
    logic             r_pend;
    logic [WAY_W-1:0] r_pend_way;

    logic [ENT_W-1:0] r_base;
    logic [TAG_W-1:0] r_tag;
    logic [ST_W-1:0]  r_rd_state;
    logic [TAG_W-1:0] r_rd_tag;

    logic             r_hit;
    logic [WAY_W-1:0] r_hit_way;
    logic             r_inv_found;
    logic [WAY_W-1:0] r_inv_way;
    logic             r_old_found;
    logic [AGE_W-1:0] r_old_age;
    logic [WAY_W-1:0] r_old_way;
    logic             r_vld [WAYS];
    logic [AGE_W-1:0] r_age [WAYS];

    logic [ADDR_W-1:0] w_block;
    logic [SET_W-1:0]  w_set;
    logic [TAG_W-1:0]  w_tag;
    logic              w_accept;
    logic              w_load_out;
    logic [ENT_W-1:0]  w_way_addr;
    logic [WAY_W-1:0]  w_cnt_way;
    logic [WAY_W-1:0]  w_used;
    logic              w_rd_vld;
    logic [AGE_W-1:0]  w_rd_age;
    logic              w_st_we;
    logic [ENT_W-1:0]  w_st_addr;
    logic [ST_W-1:0]   w_st_data;
    logic              w_tag_we;

    // Split the address into set index and tag
    assign w_block = i_byte_address >> OFF_W;
    assign w_set   = SET_W'(w_block & ADDR_W'(SETS - 1));
    assign w_tag   = TAG_W'(w_block >> SIDX_W);

    assign o_stall    = (r_state != S_IDLE);
    assign w_accept   = i_valid && !o_stall;
    assign w_load_out = (r_state == S_DONE) && (!o_valid || !i_stall);

    assign w_way_addr = r_base + ENT_W'(r_cnt);
    assign w_cnt_way  = WAY_W'(r_cnt);
    assign w_rd_vld   = r_rd_state[ST_W-1];
    assign w_rd_age   = r_rd_state[AGE_W-1:0];

    // Pick the way to use: hit, else first invalid, else oldest
    always_comb begin
        priority if (r_hit) begin
            w_used = r_hit_way;
        end else if (r_inv_found) begin
            w_used = r_inv_way;
        end else begin
            w_used = r_old_way;
        end
    end

    // Build the write-back of one way, or a clearing write
    always_comb begin
        w_st_we   = (r_state == S_CLEAR) || (r_state == S_WRITE);
        w_st_addr = (r_state == S_CLEAR) ? r_clr : w_way_addr;
        w_tag_we  = (r_state == S_WRITE) && (w_cnt_way == w_used);
        if (r_state == S_CLEAR) begin
            w_st_data = '0;
        end else if (w_cnt_way == w_used) begin
            w_st_data = {1'b1, {AGE_W{1'b0}}};
        end else if (r_vld[w_cnt_way] && (r_age[w_cnt_way] < AGE_MAX)) begin
            w_st_data = {1'b1, r_age[w_cnt_way] + 1'b1};
        end else begin
            w_st_data = {r_vld[w_cnt_way], r_age[w_cnt_way]};
        end
    end

    // Write and read the line memories
    always_ff @(posedge i_clk) begin
        if (w_st_we) begin
            mem_state[w_st_addr] <= w_st_data;
        end
        if (w_tag_we) begin
            mem_tag[w_way_addr] <= r_tag;
        end
        r_rd_state <= mem_state[w_way_addr];
        r_rd_tag   <= mem_tag[w_way_addr];
    end

    // Sequence the clearing pass, scan, write-back and result hand-off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_clr   <= '0;
            r_pend  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && !i_stall && !w_load_out) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == ENT_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_cnt   <= '0;
                        r_pend  <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_cnt < CNT_WAYS) begin
                        r_cnt  <= r_cnt + 1'b1;
                        r_pend <= 1'b1;
                    end else begin
                        r_cnt   <= '0;
                        r_pend  <= 1'b0;
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (r_cnt == CNT_LAST) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DONE: begin
                    if (w_load_out) begin
                        o_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

    // Latch the request, track hit and victim candidates, load the result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_base      <= ENT_W'(w_set * WAYS);
            r_tag       <= w_tag;
            r_hit       <= 1'b0;
            r_inv_found <= 1'b0;
            r_old_found <= 1'b0;
        end
        if (r_state == S_SCAN) begin
            r_pend_way <= w_cnt_way;
        end
        if ((r_state == S_SCAN) && r_pend) begin
            r_vld[r_pend_way] <= w_rd_vld;
            r_age[r_pend_way] <= w_rd_age;
            if (!r_hit && w_rd_vld && (r_rd_tag == r_tag)) begin
                r_hit     <= 1'b1;
                r_hit_way <= r_pend_way;
            end
            if (!r_inv_found && !w_rd_vld) begin
                r_inv_found <= 1'b1;
                r_inv_way   <= r_pend_way;
            end
            if (w_rd_vld && (!r_old_found || (w_rd_age > r_old_age))) begin
                r_old_found <= 1'b1;
                r_old_age   <= w_rd_age;
                r_old_way   <= r_pend_way;
            end
        end
        if (w_load_out) begin
            o_hit      <= r_hit;
            o_way_used <= OUT_WAY_W'(w_used);
        end
    end

    // The scan always leaves some way to use
    a_way_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> (r_hit || r_inv_found || r_old_found))
        else $error("write-back started with no way selected");

    // A hit way was seen valid during the scan
    a_hit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WRITE) && r_hit) |-> r_vld[r_hit_way])
        else $error("hit on a way that was not valid");

    // A new result only comes from the hand-off step
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside hand-off");

    // The clearing pass ends in idle
    a_clear_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (($past(r_state) == S_CLEAR) && (r_state != S_CLEAR)) |-> (r_state == S_IDLE))
        else $error("clearing pass left to a wrong state");

endmodule
